[hw/rtl/rgbl_pkg.sv]
`timescale 1ns / 1ps

package rgbl_pkg;

    localparam int COLOR_W       = 8;
    localparam int DUTY_W        = 16;
    localparam int CMD_W         = 3;
    localparam int PCOUNT_W      = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int GAMMA_ENTRIES = 256;

    localparam logic [COLOR_W-1:0]  USER_LED_CODE = 8'd2;
    localparam logic [COLOR_W-1:0]  REPEAT_FOREVER = 8'hFF;
    localparam logic [PCOUNT_W-1:0] FOREVER_RELOAD = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_RAW_SET   = 3'd1,
        CMD_FUNC_COLR = 3'd2,
        CMD_STATE     = 3'd3,
        CMD_BLINK     = 3'd4,
        CMD_APPLY_CFG = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_FUNCTION = 2'd0,
        REG_USER_RED     = 2'd1,
        REG_USER_GREEN   = 2'd2,
        REG_USER_BLUE    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } t_duty;

    localparam logic [DUTY_W-1:0] GAMMA_ROM [GAMMA_ENTRIES] = '{
        16'd0, 16'd27, 16'd56, 16'd84, 16'd113, 16'd141, 16'd170, 16'd198,
        16'd227, 16'd255, 16'd284, 16'd312, 16'd340, 16'd369, 16'd397, 16'd426,
        16'd454, 16'd483, 16'd511, 16'd540, 16'd568, 16'd597, 16'd626, 16'd657,
        16'd688, 16'd720, 16'd754, 16'd788, 16'd824, 16'd860, 16'd898, 16'd936,
        16'd976, 16'd1017, 16'd1059, 16'd1102, 16'd1146, 16'd1191, 16'd1238, 16'd1286,
        16'd1335, 16'd1385, 16'd1436, 16'd1489, 16'd1543, 16'd1598, 16'd1655, 16'd1713,
        16'd1772, 16'd1833, 16'd1895, 16'd1958, 16'd2023, 16'd2089, 16'd2156, 16'd2225,
        16'd2296, 16'd2368, 16'd2441, 16'd2516, 16'd2592, 16'd2670, 16'd2750, 16'd2831,
        16'd2914, 16'd2998, 16'd3084, 16'd3171, 16'd3260, 16'd3351, 16'd3443, 16'd3537,
        16'd3633, 16'd3731, 16'd3830, 16'd3931, 16'd4034, 16'd4138, 16'd4245, 16'd4353,
        16'd4463, 16'd4574, 16'd4688, 16'd4803, 16'd4921, 16'd5040, 16'd5161, 16'd5284,
        16'd5409, 16'd5536, 16'd5665, 16'd5796, 16'd5929, 16'd6064, 16'd6201, 16'd6340,
        16'd6482, 16'd6625, 16'd6770, 16'd6917, 16'd7067, 16'd7219, 16'd7372, 16'd7528,
        16'd7687, 16'd7847, 16'd8010, 16'd8174, 16'd8341, 16'd8511, 16'd8682, 16'd8856,
        16'd9032, 16'd9211, 16'd9392, 16'd9575, 16'd9761, 16'd9949, 16'd10139, 16'd10332,
        16'd10527, 16'd10725, 16'd10925, 16'd11127, 16'd11332, 16'd11540, 16'd11750,
        16'd11963,
        16'd12178, 16'd12395, 16'd12616, 16'd12839, 16'd13064, 16'd13292, 16'd13523,
        16'd13757,
        16'd13993, 16'd14231, 16'd14473, 16'd14717, 16'd14964, 16'd15214, 16'd15466,
        16'd15722,
        16'd15980, 16'd16240, 16'd16504, 16'd16771, 16'd17040, 16'd17312, 16'd17587,
        16'd17865,
        16'd18146, 16'd18430, 16'd18717, 16'd19006, 16'd19299, 16'd19595, 16'd19894,
        16'd20195,
        16'd20500, 16'd20808, 16'd21119, 16'd21433, 16'd21750, 16'd22070, 16'd22393,
        16'd22720,
        16'd23049, 16'd23382, 16'd23718, 16'd24057, 16'd24400, 16'd24745, 16'd25094,
        16'd25446,
        16'd25802, 16'd26160, 16'd26522, 16'd26888, 16'd27256, 16'd27628, 16'd28004,
        16'd28382,
        16'd28765, 16'd29150, 16'd29539, 16'd29932, 16'd30328, 16'd30727, 16'd31130,
        16'd31536,
        16'd31946, 16'd32360, 16'd32777, 16'd33197, 16'd33622, 16'd34049, 16'd34481,
        16'd34916,
        16'd35354, 16'd35797, 16'd36243, 16'd36692, 16'd37146, 16'd37603, 16'd38064,
        16'd38528,
        16'd38996, 16'd39469, 16'd39945, 16'd40424, 16'd40908, 16'd41395, 16'd41886,
        16'd42382,
        16'd42881, 16'd43383, 16'd43890, 16'd44401, 16'd44916, 16'd45434, 16'd45957,
        16'd46484,
        16'd47014, 16'd47549, 16'd48088, 16'd48630, 16'd49177, 16'd49728, 16'd50283,
        16'd50842,
        16'd51406, 16'd51973, 16'd52545, 16'd53120, 16'd53700, 16'd54284, 16'd54873,
        16'd55465,
        16'd56062, 16'd56663, 16'd57269, 16'd57878, 16'd58492, 16'd59111, 16'd59733,
        16'd60360,
        16'd60992, 16'd61627, 16'd62268, 16'd62912, 16'd63561, 16'd64215, 16'd64873,
        16'd65535
    };

endpackage

[hw/rtl/rgbl_cmd_if.sv]
`timescale 1ns / 1ps

interface rgbl_cmd_if
    import rgbl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COLOR_W-1:0] func_code;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] repeat_req;
    logic [COLOR_W-1:0] period_one;
    logic [COLOR_W-1:0] red_two;
    logic [COLOR_W-1:0] green_two;
    logic [COLOR_W-1:0] blue_two;
    logic [COLOR_W-1:0] period_two;

    modport source (
        output valid, command, func_code, red, green, blue, repeat_req, period_one,
               red_two, green_two, blue_two, period_two,
        input  ready
    );

    modport sink (
        input  valid, command, func_code, red, green, blue, repeat_req, period_one,
               red_two, green_two, blue_two, period_two,
        output ready
    );
endinterface

[hw/rtl/rgbl_res_if.sv]
`timescale 1ns / 1ps

interface rgbl_res_if
    import rgbl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  duty_red;
    logic [DUTY_W-1:0]  duty_green;
    logic [DUTY_W-1:0]  duty_blue;
    logic               duty_written;
    logic               blink_running;
    logic [COLOR_W-1:0] blinks_left;

    modport source (
        output valid, duty_red, duty_green, duty_blue, duty_written, blink_running,
               blinks_left,
        input  ready
    );

    modport sink (
        input  valid, duty_red, duty_green, duty_blue, duty_written, blink_running,
               blinks_left,
        output ready
    );
endinterface

[hw/rtl/rgb_led_blink_controller_top.sv]
`timescale 1ns / 1ps

// Command-driven RGB LED controller with a two-colour blink engine. Each accepted
// command request yields exactly one result: the three gamma-corrected PWM compare
// values now shown plus blink status. A request is captured in an input stage and
// resolved from there into the result register, so one request is taken every
// cycle unless the output stalls. Each result is captured in the result register
// after its request leaves the input stage. Input ready drops only when the input
// stage holds a request and the result register is full and not being taken.
// Config registers (led_function, user_red/green/blue at indexes 0..3) are meant
// to be written only while no request is in flight.
module rgb_led_blink_controller_top
    import rgbl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COLOR_W-1:0]   i_cfg_wdata,
    rgbl_cmd_if.sink             i_cmd,
    rgbl_res_if.source           o_res
);

    // config registers
    logic [COLOR_W-1:0] r_led_function;
    t_rgb               r_user;

    // input stage
    logic               r_s1_valid;
    logic [CMD_W-1:0]   r_in_command;
    logic [COLOR_W-1:0] r_in_func_code;
    t_rgb               r_in_one;
    t_rgb               r_in_two;
    logic [COLOR_W-1:0] r_in_repeat;
    logic [COLOR_W-1:0] r_in_period_one;
    logic [COLOR_W-1:0] r_in_period_two;

    // blink state
    t_rgb                r_base,   n_base;
    t_rgb                r_blk1,   n_blk1;
    t_rgb                r_blk2,   n_blk2;
    logic [COLOR_W-1:0]  r_len1,   n_len1;
    logic [COLOR_W-1:0]  r_len2,   n_len2;
    logic [COLOR_W-1:0]  r_repeat, n_repeat;
    logic [PCOUNT_W-1:0] r_pcount, n_pcount;
    logic [COLOR_W-1:0]  r_timer,  n_timer;

    // result register; the shown duty doubles as persistent state
    logic               r_out_valid;
    t_duty              r_shown;
    logic               r_wrote;
    logic               r_running;
    logic [COLOR_W-1:0] r_left;

    logic                advance;
    logic                show;
    t_rgb                show_rgb;
    t_duty               n_shown;
    logic [PCOUNT_W-1:0] pcount_dec;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_cmd.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_function <= 8'd1;
            r_user         <= '{red: 8'd60, green: 8'd60, blue: 8'd100};
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_LED_FUNCTION: r_led_function <= i_cfg_wdata;
                REG_USER_RED:     r_user.red     <= i_cfg_wdata;
                REG_USER_GREEN:   r_user.green   <= i_cfg_wdata;
                REG_USER_BLUE:    r_user.blue    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_command    <= i_cmd.command;
            r_in_func_code  <= i_cmd.func_code;
            r_in_one        <= '{red: i_cmd.red, green: i_cmd.green, blue: i_cmd.blue};
            r_in_two        <= '{red: i_cmd.red_two, green: i_cmd.green_two,
                                 blue: i_cmd.blue_two};
            r_in_repeat     <= i_cmd.repeat_req;
            r_in_period_one <= i_cmd.period_one;
            r_in_period_two <= i_cmd.period_two;
        end
    end

    assign pcount_dec = r_pcount - PCOUNT_W'(1);

    always_comb begin
        n_base   = r_base;
        n_blk1   = r_blk1;
        n_blk2   = r_blk2;
        n_len1   = r_len1;
        n_len2   = r_len2;
        n_repeat = r_repeat;
        n_pcount = r_pcount;
        n_timer  = r_timer;
        show     = 1'b0;
        show_rgb = r_base;

        unique case (r_in_command)
            CMD_TICK: begin
                if (r_pcount != '0) begin
                    if (r_timer > 8'd1) begin
                        n_timer = r_timer - 8'd1;
                    end else if (r_pcount[0]) begin
                        // second colour ends
                        n_pcount = pcount_dec;
                        n_timer  = r_len1;
                        if (pcount_dec == '0) begin
                            if (r_repeat == REPEAT_FOREVER) begin
                                n_pcount = FOREVER_RELOAD;
                            end else begin
                                show     = 1'b1;
                                show_rgb = r_base;
                            end
                        end else begin
                            show     = 1'b1;
                            show_rgb = r_blk1;
                        end
                    end else begin
                        show     = 1'b1;
                        show_rgb = r_blk2;
                        n_pcount = pcount_dec;
                        n_timer  = r_len2;
                    end
                end
            end
            CMD_RAW_SET: begin
                show     = 1'b1;
                show_rgb = r_in_one;
            end
            CMD_FUNC_COLR: begin
                if (r_in_func_code == r_led_function) begin
                    n_base   = r_in_one;
                    n_repeat = '0;
                    n_pcount = '0;
                    show     = 1'b1;
                    show_rgb = r_in_one;
                end
            end
            CMD_STATE: begin
                n_base   = r_in_one;
                show     = 1'b1;
                show_rgb = r_in_one;
            end
            CMD_BLINK: begin
                n_repeat = r_in_repeat;
                n_pcount = {r_in_repeat, 1'b0};
                n_blk1   = r_in_one;
                n_blk2   = r_in_two;
                n_len1   = (r_in_period_one != '0) ? r_in_period_one : 8'd1;
                n_len2   = (r_in_period_two != '0) ? r_in_period_two : 8'd1;
                show     = 1'b1;
                if (r_in_repeat != '0) begin
                    show_rgb = r_in_one;
                    n_timer  = n_len1;
                end else begin
                    show_rgb = r_base;
                end
            end
            CMD_APPLY_CFG: begin
                show = 1'b1;
                if (r_led_function == USER_LED_CODE) begin
                    n_base   = r_user;
                    show_rgb = r_user;
                end else begin
                    show_rgb = '0;
                end
            end
            default: ;
        endcase

        n_shown = r_shown;
        if (show) begin
            n_shown.red   = GAMMA_ROM[show_rgb.red];
            n_shown.green = GAMMA_ROM[show_rgb.green];
            n_shown.blue  = GAMMA_ROM[show_rgb.blue];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_blk1      <= '0;
            r_blk2      <= '0;
            r_len1      <= 8'd1;
            r_len2      <= 8'd1;
            r_repeat    <= '0;
            r_pcount    <= '0;
            r_timer     <= '0;
            r_shown     <= '0;
            r_wrote     <= 1'b0;
            r_running   <= 1'b0;
            r_left      <= '0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_base    <= n_base;
                r_blk1    <= n_blk1;
                r_blk2    <= n_blk2;
                r_len1    <= n_len1;
                r_len2    <= n_len2;
                r_repeat  <= n_repeat;
                r_pcount  <= n_pcount;
                r_timer   <= n_timer;
                r_shown   <= n_shown;
                r_wrote   <= show;
                r_running <= (n_pcount != '0);
                r_left    <= (n_repeat == REPEAT_FOREVER) ? REPEAT_FOREVER
                                                          : n_pcount[PCOUNT_W-1:1];
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.duty_red      = r_shown.red;
    assign o_res.duty_green    = r_shown.green;
    assign o_res.duty_blue     = r_shown.blue;
    assign o_res.duty_written  = r_wrote;
    assign o_res.blink_running = r_running;
    assign o_res.blinks_left   = r_left;

    // a running blink always has a live phase timer
    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount != '0 |-> r_timer != '0)
        else $error("phase timer zero while blink running");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len1 != '0 && r_len2 != '0)
        else $error("phase length of zero stored");

    // a stalled result must hold the request waiting in the input stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_res.ready |=> r_s1_valid && r_out_valid)
        else $error("request lost during output stall");

    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_running == (r_pcount != '0))
        else $error("blink status out of step with phase count");

endmodule
